@@ src/deadline_timer_queue_defines.svh @@
// ----------------------------------------------------------------------------
// deadline_timer_queue_defines
// Assertion macros for the deadline timer queue.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// a condition implies a consequence in the same cycle
`define DTQ_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// a condition implies a consequence in the next cycle
`define DTQ_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants shared by the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;
    localparam int DTQ_SLOTS     = 16;
    localparam int TIME_W        = 48;
    localparam int PERIOD_W      = 32;
    localparam int MIN_W         = 20;
    localparam int ID_W          = 4;
    localparam logic [MIN_W-1:0] MIN_REARM_RESET = 20'd100;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic {OP_ADD = 1'b0, OP_TICK = 1'b1} op_t;

    typedef struct packed {
        logic                operation;
        logic [ID_W-1:0]     timer_id;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   now_time;
    } dtq_in_t;

    typedef struct packed {
        logic              expired_valid;
        logic [ID_W-1:0]   expired_id;
        logic              last;
        logic              accepted;
        logic              new_earliest;
        logic              rearm_valid;
        logic [TIME_W-1:0] rearm_delay;
        logic [TIME_W-1:0] next_deadline;
    } dtq_out_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                write;
        logic                expire;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   now_time;
    } dtq_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_PICK, ST_FIN, ST_OUT
    } dtq_state_t;
endpackage
`default_nettype wire

@@ src/dtq_cell.sv @@
// ----------------------------------------------------------------------------
// dtq_cell
// One timer slot; compares its deadline with the value handed from its
// neighbour and registers the smaller one with its slot number.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_cell #(
    parameter int IDX_W = 4,
    parameter logic [IDX_W-1:0] MY_IDX = '0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire dtq_pkg::dtq_cmd_t       cmd,
    input  wire                          sel,
    input  wire                          due_only,
    input  wire                          min_in_vld,
    input  wire [dtq_pkg::TIME_W-1:0]    min_in,
    input  wire [IDX_W-1:0]              min_in_idx,
    output logic                         min_out_vld,
    output logic [dtq_pkg::TIME_W-1:0]   min_out,
    output logic [IDX_W-1:0]             min_out_idx,
    output logic                         active,
    output logic                         due
);
    import dtq_pkg::*;

    logic                active_reg;
    logic                due_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W:0]     reload;
    logic                cand;
    logic                min_vld_reg, min_vld_next;
    logic [TIME_W-1:0]   min_reg, min_next;
    logic [IDX_W-1:0]    min_idx_reg, min_idx_next;

    assign reload = {1'b0, cmd.now_time} + {{(TIME_W-PERIOD_W+1){1'b0}}, period_reg};
    assign cand   = active_reg && (!due_only || due_reg);

    // keep the earlier entry; ties go to the lower slot, which is upstream
    always_comb
    begin
        if (cand && (!min_in_vld || deadline_reg < min_in))
        begin
            min_vld_next = 1'b1;
            min_next     = deadline_reg;
            min_idx_next = MY_IDX;
        end
        else
        begin
            min_vld_next = min_in_vld;
            min_next     = min_in;
            min_idx_next = min_in_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            due_reg     <= 1'b0;
            min_vld_reg <= 1'b0;
        end
        else
        begin
            min_vld_reg <= min_vld_next;
            if (sel && cmd.write)
            begin
                active_reg <= 1'b1;
            end
            else if (sel && cmd.expire)
            begin
                due_reg <= 1'b0;
                if (period_reg == '0)
                    active_reg <= 1'b0;
            end
            else if (!sel && !cmd.write && !cmd.expire && !due_only)
            begin
                // refresh due flags outside picks, so at the start of a tick too
                due_reg <= active_reg && (deadline_reg <= cmd.now_time);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        if (sel && cmd.write)
        begin
            deadline_reg <= cmd.deadline;
            period_reg   <= cmd.period;
        end
        else if (sel && cmd.expire && period_reg != '0)
        begin
            deadline_reg <= reload[TIME_W] ? TIME_MAX : reload[TIME_W-1:0];
        end
    end

    assign min_out_vld = min_vld_reg;
    assign min_out     = min_reg;
    assign min_out_idx = min_idx_reg;
    assign active      = active_reg;
    assign due         = due_reg;
endmodule
`default_nettype wire

@@ src/deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Earliest-deadline timer queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each chain pass (pre-add minimum, each pick, final minimum) waits for the
// registered chain to settle. One item at a time: the input stalls until
// the last result is loaded, and longer under output stall.
// Reset: clears every slot, the controller and the output; min_rearm_delay is 100.
`default_nettype none
module deadline_timer_queue #(
    parameter int SLOTS = dtq_pkg::DTQ_SLOTS
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire dtq_pkg::dtq_in_t         in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output dtq_pkg::dtq_out_t             out_data,
    input  wire                           cfg_we,
    input  wire [dtq_pkg::MIN_W-1:0]      cfg_data
);
    import dtq_pkg::*;
    `include "deadline_timer_queue_defines.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    dtq_state_t state_reg, state_next;
    dtq_in_t    item_reg;
    logic [MIN_W-1:0] min_rearm_reg;
    dtq_out_t   out_reg, out_next;
    logic       out_vld_reg, out_vld_next;
    logic       item_load;
    // end of the chain, registered
    logic              pick_vld_reg;
    logic [TIME_W-1:0] pick_dl_reg;
    logic              pend_reg, pend_next;    // a picked timer awaits output
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              prev_earliest_reg;  // any timer active before the add
    logic [TIME_W-1:0] prev_dl_reg;
    logic              acc_reg, acc_next;
    // cycles since the chain inputs last changed
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              settled;

    logic              chain_vld  [SLOTS+1];
    logic [TIME_W-1:0] chain_dl   [SLOTS+1];
    logic [IDX_W-1:0]  chain_idx  [SLOTS+1];
    logic [SLOTS-1:0]  sel_vec, active_vec, due_vec;
    dtq_cmd_t          cmd;
    logic              due_only;
    logic              id_ok;
    logic [IDX_W-1:0]  id_idx;

    assign chain_vld[0] = 1'b0;
    assign chain_dl[0]  = '0;
    assign chain_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            dtq_cell #(.IDX_W(IDX_W), .MY_IDX(IDX_W'(g))) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel(sel_vec[g]),
                .due_only(due_only),
                .min_in_vld(chain_vld[g]), .min_in(chain_dl[g]),
                .min_in_idx(chain_idx[g]),
                .min_out_vld(chain_vld[g+1]), .min_out(chain_dl[g+1]),
                .min_out_idx(chain_idx[g+1]),
                .active(active_vec[g]), .due(due_vec[g])
            );
        end
    endgenerate

    // rearm delay: clamp the distance to the earliest deadline
    function automatic logic [TIME_W-1:0] delay_f(input logic [TIME_W-1:0] when_t,
                                                  input logic [TIME_W-1:0] now_t,
                                                  input logic [MIN_W-1:0] mn);
        logic [TIME_W-1:0] d;
        d = (when_t > now_t) ? when_t - now_t : '0;
        if (d < {{(TIME_W-MIN_W){1'b0}}, mn})
            d = {{(TIME_W-MIN_W){1'b0}}, mn};
        return d;
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign item_load = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign id_ok     = (32'(item_reg.timer_id) < 32'(SLOTS));
    assign id_idx    = IDX_W'(item_reg.timer_id);
    // the chain end is valid once every cell stage has seen stable inputs
    assign settled   = (cnt_reg == CNT_W'(SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_vld_reg   <= 1'b0;
            min_rearm_reg <= MIN_REARM_RESET;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            if (cfg_we)
                min_rearm_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
            item_reg <= in_data;
        out_reg           <= out_next;
        pend_idx_reg      <= pend_idx_next;
        acc_reg           <= acc_next;
        pick_vld_reg      <= chain_vld[SLOTS];
        pick_dl_reg       <= chain_dl[SLOTS];
        if (state_reg == ST_SCAN)
        begin
            prev_earliest_reg <= chain_vld[SLOTS];
            prev_dl_reg       <= chain_dl[SLOTS];
        end
    end

    // controller: SCAN latches due flags (tick) or takes the pre-add minimum
    // and writes a free slot (add); PICK expires the earliest due timer
    // per settled pass; FIN waits for the all-active minimum; OUT loads the result.
    always_comb
    begin
        state_next    = state_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && out_stall;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        sel_vec       = '0;
        due_only      = 1'b0;
        cmd.write     = 1'b0;
        cmd.expire    = 1'b0;
        cmd.period    = item_reg.period;
        cmd.deadline  = item_reg.deadline;
        cmd.now_time  = item_reg.now_time;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_load)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (item_reg.operation == OP_TICK)
                begin
                    // due flags latch at this edge
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_PICK;
                end
                else if (!settled)
                    cnt_next = cnt_reg + CNT_W'(1);
                else
                begin
                    acc_next = id_ok && !active_vec[id_idx];
                    if (acc_next)
                    begin
                        cmd.write = 1'b1;
                        sel_vec[id_idx] = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_PICK:
            begin
                due_only = 1'b1;
                if (!settled)
                    cnt_next = cnt_reg + CNT_W'(1);
                else if (chain_vld[SLOTS])
                begin
                    // hold the pick while the previous one cannot move out
                    if (!pend_reg || !(out_vld_reg && out_stall))
                    begin
                        if (pend_reg)
                        begin
                            out_next = '0;
                            out_next.expired_valid = 1'b1;
                            out_next.expired_id = ID_W'(pend_idx_reg);
                            out_vld_next = 1'b1;
                        end
                        cmd.expire = 1'b1;
                        sel_vec[chain_idx[SLOTS]] = 1'b1;
                        pend_next = 1'b1;
                        pend_idx_next = chain_idx[SLOTS];
                        cnt_next = '0;
                    end
                end
                else
                begin
                    // the last picked timer goes out with the final result
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!settled)
                    cnt_next = cnt_reg + CNT_W'(1);
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // for a tick, pick_*_reg holds the minimum over all active slots
                if (!(out_vld_reg && out_stall))
                begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    if (item_reg.operation == OP_ADD)
                    begin
                        out_next.accepted = acc_reg;
                        out_next.new_earliest = acc_reg &&
                            (!prev_earliest_reg || item_reg.deadline < prev_dl_reg);
                        out_next.rearm_valid = out_next.new_earliest;
                        if (out_next.new_earliest)
                        begin
                            out_next.rearm_delay = delay_f(item_reg.deadline,
                                item_reg.now_time, min_rearm_reg);
                            out_next.next_deadline = item_reg.deadline;
                        end
                        else
                            out_next.next_deadline = prev_earliest_reg ? prev_dl_reg : '0;
                    end
                    else
                    begin
                        out_next.expired_valid = pend_reg;
                        out_next.expired_id = pend_reg ? ID_W'(pend_idx_reg) : '0;
                        out_next.rearm_valid = pick_vld_reg;
                        out_next.next_deadline = pick_vld_reg ? pick_dl_reg : '0;
                        if (pick_vld_reg)
                            out_next.rearm_delay = delay_f(pick_dl_reg,
                                item_reg.now_time, min_rearm_reg);
                    end
                    out_vld_next = 1'b1;
                    pend_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `DTQ_ASSERT_IMP(a_one_sel, 1'b1, $onehot0(sel_vec))
    `DTQ_ASSERT_IMP(a_stall_busy, state_reg != ST_IDLE, in_stall)
    `DTQ_ASSERT_NEXT(a_out_hold, out_vld_reg && out_stall, out_vld_reg && $stable(out_reg))
    `DTQ_ASSERT_IMP(a_pick_due, state_reg == ST_PICK && settled && chain_vld[SLOTS], due_vec[chain_idx[SLOTS]])
endmodule
`default_nettype wire

@@ dv/tb_deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue
// Self-checking bench for the deadline timer queue. It keeps its own copy
// of the timer slots and the minimum rearm delay, and works out the results
// of each item it transfers, save directed rows that come with their own.
// It starts with a table of directed items and then runs random items in
// several phases with different rearm minimums and idling on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RAND_PER_PHASE = 82;
    localparam int NUM_PHASES     = 5;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    dtq_in_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    dtq_out_t          out_data;
    logic              cfg_we = 1'b0;
    logic [MIN_W-1:0]  cfg_data = '0;

    // Own copy of the timer slots and the rearm minimum
    logic [TIME_W-1:0]   timer_deadline [DTQ_SLOTS];
    logic [PERIOD_W-1:0] timer_period   [DTQ_SLOTS];
    bit                  timer_active   [DTQ_SLOTS];
    logic [MIN_W-1:0]    min_delay;

    dtq_out_t pending_results[$];
    int       mismatches = 0;

    // Idling knobs (percent of cycles), the output hold-off and the quiet-time watchdog
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    logic [TIME_W-1:0] clock_now;

    typedef struct {
        dtq_in_t  item;
        bit       typed;
        dtq_out_t want;
    } stim_row_t;

    stim_row_t directed[$];

    deadline_timer_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rearm_after(logic [TIME_W-1:0] when,
                                                     logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] d;
        d = (when > now) ? when - now : '0;
        if (d < TIME_W'(min_delay))
            d = TIME_W'(min_delay);
        return d;
    endfunction

    function automatic bit earliest_deadline(output logic [TIME_W-1:0] when);
        bit found;
        found = 1'b0;
        when = '0;
        for (int i = 0; i < DTQ_SLOTS; i++)
        begin
            if (timer_active[i] && (!found || timer_deadline[i] < when))
            begin
                when = timer_deadline[i];
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Update the slot copy for one item; queue its results when asked to
    task automatic predict_timer_results(input dtq_in_t it, input bit queue_them);
        dtq_out_t          r;
        logic [TIME_W-1:0] soonest;
        logic [TIME_W:0]   reload;
        bit                any;
        bit                due [DTQ_SLOTS];
        int                order[$];
        int                pick;

        r = '0;
        if (op_t'(it.operation) == OP_ADD)
        begin
            r.last = 1'b1;
            if (!timer_active[it.timer_id])
            begin
                any = earliest_deadline(soonest);
                r.new_earliest = !any || it.deadline < soonest;
                timer_deadline[it.timer_id] = it.deadline;
                timer_period[it.timer_id]   = it.period;
                timer_active[it.timer_id]   = 1'b1;
                r.accepted = 1'b1;
                if (r.new_earliest)
                begin
                    r.rearm_valid = 1'b1;
                    r.rearm_delay = rearm_after(it.deadline, it.now_time);
                end
            end
            void'(earliest_deadline(soonest));
            r.next_deadline = soonest;
            if (queue_them)
                pending_results.push_back(r);
            return;
        end

        // tick: collect due slots by deadline, lowest slot first on a tie
        for (int i = 0; i < DTQ_SLOTS; i++)
            due[i] = timer_active[i] && timer_deadline[i] <= it.now_time;
        forever
        begin
            pick = -1;
            for (int i = 0; i < DTQ_SLOTS; i++)
                if (due[i] && (pick < 0 || timer_deadline[i] < timer_deadline[pick]))
                    pick = i;
            if (pick < 0)
                break;
            due[pick] = 1'b0;
            order.push_back(pick);
        end
        foreach (order[k])
        begin
            if (timer_period[order[k]] != '0)
            begin
                reload = {1'b0, it.now_time} + timer_period[order[k]];
                timer_deadline[order[k]] = reload[TIME_W] ? TIME_MAX : reload[TIME_W-1:0];
            end
            else
                timer_active[order[k]] = 1'b0;
        end
        any = earliest_deadline(soonest);
        if (!queue_them)
            return;
        if (order.size() == 0)
        begin
            r.last = 1'b1;
            r.rearm_valid = any;
            r.rearm_delay = any ? rearm_after(soonest, it.now_time) : '0;
            r.next_deadline = any ? soonest : '0;
            pending_results.push_back(r);
            return;
        end
        foreach (order[k])
        begin
            r = '0;
            r.expired_valid = 1'b1;
            r.expired_id = order[k][ID_W-1:0];
            if (k == order.size() - 1)
            begin
                r.last = 1'b1;
                r.rearm_valid = any;
                r.rearm_delay = any ? rearm_after(soonest, it.now_time) : '0;
                r.next_deadline = any ? soonest : '0;
            end
            pending_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        dtq_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer", out_data.next_deadline, '0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.expired_valid !== want.expired_valid)
                    report_mismatch("expired_valid", TIME_W'(out_data.expired_valid),
                                    TIME_W'(want.expired_valid));
                if (out_data.expired_id !== want.expired_id)
                    report_mismatch("expired_id", TIME_W'(out_data.expired_id),
                                    TIME_W'(want.expired_id));
                if (out_data.last !== want.last)
                    report_mismatch("last", TIME_W'(out_data.last), TIME_W'(want.last));
                if (out_data.accepted !== want.accepted)
                    report_mismatch("accepted", TIME_W'(out_data.accepted),
                                    TIME_W'(want.accepted));
                if (out_data.new_earliest !== want.new_earliest)
                    report_mismatch("new_earliest", TIME_W'(out_data.new_earliest),
                                    TIME_W'(want.new_earliest));
                if (out_data.rearm_valid !== want.rearm_valid)
                    report_mismatch("rearm_valid", TIME_W'(out_data.rearm_valid),
                                    TIME_W'(want.rearm_valid));
                if (out_data.rearm_delay !== want.rearm_delay)
                    report_mismatch("rearm_delay", out_data.rearm_delay, want.rearm_delay);
                if (out_data.next_deadline !== want.next_deadline)
                    report_mismatch("next_deadline", out_data.next_deadline, want.next_deadline);
            end
        end
    end

    // Receiver: a long hold-off first if one was asked for, else random stall
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: give up after too long with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("deadline_timer_queue regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Offer one item from a falling edge; hold it until the transfer
    task automatic send_item(input dtq_in_t it, input bit typed, input dtq_out_t want);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_timer_results(it, !typed);
        if (typed)
            pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the rearm minimum with the block idle
    task automatic set_min_delay(input logic [MIN_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        min_delay = value;
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic dtq_in_t random_item();
        dtq_in_t it;
        int      pick;
        pick = $urandom_range(0, 99);
        it = '0;
        it.timer_id = ID_W'($urandom_range(0, DTQ_SLOTS - 1));
        if (pick < 10)
        begin
            // noise: any field pattern at all
            it.operation = 1'($urandom_range(0, 1));
            it.deadline  = rand_time();
            it.period    = $urandom;
            it.now_time  = rand_time();
            return it;
        end
        if (pick < 55)
        begin
            it.operation = OP_ADD;
            it.now_time  = clock_now;
            it.deadline  = clock_now + $urandom_range(0, 2500);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: it.period = '0;
                6:                it.period = $urandom;
                default:          it.period = $urandom_range(1, 3000);
            endcase
            return it;
        end
        clock_now = clock_now + $urandom_range(0, 1500);
        it.operation = OP_TICK;
        it.now_time  = clock_now;
        it.deadline  = rand_time();
        it.period    = $urandom;
        return it;
    endfunction

    function automatic stim_row_t make_row(input op_t op, input int id,
                                           input logic [TIME_W-1:0] dl,
                                           input logic [PERIOD_W-1:0] per,
                                           input logic [TIME_W-1:0] now,
                                           input bit typed, input dtq_out_t want);
        stim_row_t row;
        row.item.operation = op;
        row.item.timer_id  = id[ID_W-1:0];
        row.item.deadline  = dl;
        row.item.period    = per;
        row.item.now_time  = now;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [MIN_W-1:0] phase_min [NUM_PHASES];
        dtq_out_t         none;

        phase_min = '{MIN_W'(1), MIN_W'(1000000), MIN_W'(0), {MIN_W{1'b1}}, MIN_W'(500)};
        none = '0;
        for (int i = 0; i < DTQ_SLOTS; i++)
        begin
            timer_active[i]   = 1'b0;
            timer_deadline[i] = '0;
            timer_period[i]   = '0;
        end
        min_delay = MIN_REARM_RESET;

        // Directed table: the plain rows carry their results, the rest
        // go through the predictor.
        // tick with nothing active: a lone last result
        directed.push_back(make_row(OP_TICK, 0, 0, 0, 0, 1,
                                    '{0, 0, 1, 0, 0, 0, 48'd0, 48'd0}));
        // first add becomes the earliest
        directed.push_back(make_row(OP_ADD, 0, 5000, 0, 0, 1,
                                    '{0, 0, 1, 1, 1, 1, 48'd5000, 48'd5000}));
        // add to a busy slot is refused
        directed.push_back(make_row(OP_ADD, 0, 10, 7, 0, 1,
                                    '{0, 0, 1, 0, 0, 0, 48'd0, 48'd5000}));
        // later deadline leaves the earliest alone
        directed.push_back(make_row(OP_ADD, 15, 5050, 0, 5000, 1,
                                    '{0, 0, 1, 1, 0, 0, 48'd0, 48'd5000}));
        // new earliest, delay clamped up to the reset minimum
        directed.push_back(make_row(OP_ADD, 3, 4990, 100, 4950, 1,
                                    '{0, 0, 1, 1, 1, 1, 48'd100, 48'd4990}));
        // equal deadline is not a new earliest
        directed.push_back(make_row(OP_ADD, 7, 4990, 0, 4950, 0, none));
        // several due at once, ordered by deadline then slot
        directed.push_back(make_row(OP_TICK, 0, 0, 0, 5000, 0, none));
        directed.push_back(make_row(OP_ADD, 2, 100, 5, 200, 0, none));
        directed.push_back(make_row(OP_ADD, 9, TIME_MAX, '1, TIME_MAX - 10, 0, none));
        directed.push_back(make_row(OP_ADD, 12, TIME_MAX - 3, 1, 0, 0, none));
        // reloads saturate at the top of the time range
        directed.push_back(make_row(OP_TICK, 0, 0, 0, TIME_MAX, 0, none));
        directed.push_back(make_row(OP_TICK, 5, TIME_MAX, '1, TIME_MAX, 0, none));
        directed.push_back(make_row(OP_ADD, 1, 0, 0, TIME_MAX, 0, none));
        directed.push_back(make_row(OP_ADD, 4, 0, '1, 0, 0, none));
        // tick with garbage in the ignored fields
        directed.push_back(make_row(OP_TICK, 15, TIME_MAX, '1, 0, 0, none));
        directed.push_back(make_row(OP_TICK, 6, 0, 0, 12345, 0, none));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].want);
        in_valid <= 1'b0;

        clock_now = 48'd20000;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // the sender waits here until every result is back
            set_min_delay(phase_min[p]);
            case (p)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 51; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 51; end
                3:       begin sender_idle_pct = 16; stall_pct = 16; end
                default:
                begin
                    // hold the output off long enough to back the input up
                    sender_idle_pct = 0;
                    stall_pct = 0;
                    hold_request = 400;
                end
            endcase
            if (p == 3)
                clock_now = TIME_MAX - 48'd200000;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_item(random_item(), 1'b0, none);
            in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
            $display("deadline_timer_queue regression: pass");
        else
            $display("deadline_timer_queue regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
